### hdl/kcdt_pkg.sv
// ----------------------------------------------------------------------------
// kcdt_pkg
// Shared types and constants for the keyed cooldown timer table.
// ----------------------------------------------------------------------------
package kcdt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int TIMER_BITS    = 8;

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int OP_W    = 2;
    localparam int OWNER_W = 16;
    localparam int ABIL_W  = 4;
    localparam int DUR_W   = 8;
    localparam int OCC_W   = 7;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [OP_W-1:0] {
        OP_QUERY = 2'd0,
        OP_START = 2'd1,
        OP_CLEAR = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef struct packed {
        logic [OWNER_W-1:0]    owner;
        logic [ABIL_W-1:0]     ability;
        logic [TIMER_BITS-1:0] timer;
    } t_entry;

    typedef struct packed {
        logic             load;
        logic             eval;
        logic             out_load;
        logic [IDX_W-1:0] rd_idx;
        logic [IDX_W-1:0] ev_idx;
    } t_cmd;

    function automatic logic [TIMER_BITS-1:0] sat_dur(input logic [DUR_W-1:0] d);
        logic [32:0] d_ext;
        logic [32:0] tmax;
        d_ext = 33'(d);
        tmax  = (33'd1 << TIMER_BITS) - 33'd1;
        if (d_ext > tmax) begin
            return TIMER_BITS'(tmax);
        end
        return TIMER_BITS'(d_ext);
    endfunction

endpackage

### hdl/kcdt_ctrl.sv
// ----------------------------------------------------------------------------
// kcdt_ctrl
// Sequencer: accepts a word, sweeps the table one entry per cycle, then
// hands the result to the output register.
// ----------------------------------------------------------------------------
module kcdt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output kcdt_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_LAST,
        ST_RESULT
    } t_state;

    t_state                     r_state;
    logic [kcdt_pkg::IDX_W-1:0] r_idx;
    logic [kcdt_pkg::IDX_W-1:0] r_ev_idx;
    logic                       r_ev_valid;
    logic                       r_out_valid;
    logic                       out_load;
    logic                       in_acc;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_load    = (r_state == ST_RESULT) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = in_acc;
        o_cmd.eval     = r_ev_valid;
        o_cmd.out_load = out_load;
        o_cmd.rd_idx   = r_idx;
        o_cmd.ev_idx   = r_ev_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_ev_idx    <= '0;
            r_ev_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ev_valid <= (r_state == ST_SWEEP);
            r_ev_idx   <= r_idx;

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_idx   <= '0;
                        r_state <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == kcdt_pkg::LAST_IDX) begin
                        r_state <= ST_LAST;
                    end
                end
                ST_LAST: begin
                    r_state <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/kcdt_dpath.sv
// ----------------------------------------------------------------------------
// kcdt_dpath
// Entry store, valid bits, live count and result register. One entry is
// read and evaluated per cycle under control of the sequencer.
// ----------------------------------------------------------------------------
module kcdt_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  kcdt_pkg::t_cmd                 i_cmd,
    input  logic [kcdt_pkg::OP_W-1:0]      i_opcode,
    input  logic [kcdt_pkg::OWNER_W-1:0]   i_owner_id,
    input  logic [kcdt_pkg::ABIL_W-1:0]    i_ability_id,
    input  logic [kcdt_pkg::DUR_W-1:0]     i_duration,
    output logic                           o_active,
    output logic                           o_dropped,
    output logic [kcdt_pkg::OCC_W-1:0]     o_occupancy
);

    kcdt_pkg::t_entry                   r_mem [kcdt_pkg::TABLE_ENTRIES];
    kcdt_pkg::t_entry                   r_rd_data;
    logic [kcdt_pkg::TABLE_ENTRIES-1:0] r_valid;
    logic [kcdt_pkg::CNT_W-1:0]         r_count;

    kcdt_pkg::t_op                      r_op;
    logic [kcdt_pkg::OWNER_W-1:0]       r_owner;
    logic [kcdt_pkg::ABIL_W-1:0]        r_ability;
    logic [kcdt_pkg::DUR_W-1:0]         r_dur;
    logic                               r_hit;
    logic                               r_placed;

    logic                               r_active;
    logic                               r_dropped;
    logic [kcdt_pkg::OCC_W-1:0]         r_occ;

    logic                               ent_v;
    logic                               own_eq;
    logic                               set_v;
    logic                               clr_v;
    logic                               hit;
    logic                               wr_en;
    kcdt_pkg::t_entry                   wdata;
    logic [31:0]                        cnt_ext;

    assign ent_v   = r_valid[i_cmd.ev_idx];
    assign own_eq  = (r_rd_data.owner == r_owner);
    assign cnt_ext = 32'(r_count);

    always_comb begin
        set_v = 1'b0;
        clr_v = 1'b0;
        hit   = 1'b0;
        wr_en = 1'b0;
        wdata = r_rd_data;
        case (r_op)
            kcdt_pkg::OP_QUERY: begin
                hit = i_cmd.eval && ent_v && own_eq && (r_rd_data.ability == r_ability);
            end
            kcdt_pkg::OP_START: begin
                if (i_cmd.eval && (r_dur != '0) && !r_placed && !ent_v) begin
                    set_v         = 1'b1;
                    wr_en         = 1'b1;
                    wdata.owner   = r_owner;
                    wdata.ability = r_ability;
                    wdata.timer   = kcdt_pkg::sat_dur(r_dur);
                end
            end
            kcdt_pkg::OP_CLEAR: begin
                clr_v = i_cmd.eval && ent_v && own_eq;
            end
            kcdt_pkg::OP_TICK: begin
                if (i_cmd.eval && ent_v) begin
                    if (r_rd_data.timer == '0) begin
                        clr_v = 1'b1;
                    end else begin
                        wr_en       = 1'b1;
                        wdata.timer = r_rd_data.timer - 1'b1;
                    end
                end
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_cmd.rd_idx];
        if (wr_en) begin
            r_mem[i_cmd.ev_idx] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else begin
            if (set_v) begin
                r_valid[i_cmd.ev_idx] <= 1'b1;
                r_count               <= r_count + 1'b1;
            end else if (clr_v) begin
                r_valid[i_cmd.ev_idx] <= 1'b0;
                r_count               <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= kcdt_pkg::t_op'(i_opcode);
            r_owner   <= i_owner_id;
            r_ability <= i_ability_id;
            r_dur     <= i_duration;
            r_hit     <= 1'b0;
            r_placed  <= 1'b0;
        end else begin
            if (hit) begin
                r_hit <= 1'b1;
            end
            if (set_v) begin
                r_placed <= 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_active  <= r_hit;
            r_dropped <= (r_op == kcdt_pkg::OP_START) && (r_dur != '0) && !r_placed;
            r_occ     <= cnt_ext[kcdt_pkg::OCC_W-1:0];
        end
    end

    assign o_active    = r_active;
    assign o_dropped   = r_dropped;
    assign o_occupancy = r_occ;

endmodule

### hdl/keyed_cooldown_timer_table.sv
// A word is accepted only while idle; the table is then swept one entry per cycle over the
// entry store (one read port and one write port), and a new word is taken only once the
// previous result has moved into the output register.
// Reset: synchronous, active low; all valid bits and the live count clear at once,
// no clearing pass. Reset also drops any result waiting in the output register.
// ----------------------------------------------------------------------------
// keyed_cooldown_timer_table
// Table of countdown timers keyed by owner and ability: query, start,
// clear owner and tick, each swept over all entries.
// ----------------------------------------------------------------------------
module keyed_cooldown_timer_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] opcode, [17:2] owner_id, [21:18] ability_id, [29:22] duration
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] active, [1] dropped, [8:2] occupancy
    output logic [15:0] m_axis_tdata
);

    kcdt_pkg::t_cmd                 cmd;
    logic                           active;
    logic                           dropped;
    logic [kcdt_pkg::OCC_W-1:0]     occupancy;

    kcdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    kcdt_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_opcode     (s_axis_tdata[1:0]),
        .i_owner_id   (s_axis_tdata[17:2]),
        .i_ability_id (s_axis_tdata[21:18]),
        .i_duration   (s_axis_tdata[29:22]),
        .o_active     (active),
        .o_dropped    (dropped),
        .o_occupancy  (occupancy)
    );

    assign m_axis_tdata = {7'b0, occupancy, dropped, active};

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for keyed_cooldown_timer_table. A short directed
// sequence covers the empty table, zero durations, duplicates, lowest-slot
// reuse, removal at timer zero and clears that hit nothing. Randomized phases
// then fill, drain and churn the table. Each accepted input word updates a
// local model of the table, and each output word is checked against it.
// Both stream sides idle at random; the output side also holds off for a
// long stretch once.
// ----------------------------------------------------------------------------
module testbench;

    import kcdt_pkg::*;

    localparam int          TOTAL_WORDS    = 1900;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned HOLD_START     = 20000;
    localparam int unsigned HOLD_CYCLES    = 3000;
    localparam int unsigned SETTLE_CYCLES  = 200;
    localparam int          POOL_SIZE      = 6;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} t_mix;

    typedef struct {
        logic             active;
        logic             dropped;
        logic [OCC_W-1:0] occupancy;
    } t_cooldown_result;

    class t_cooldown_scoreboard;
        bit                    live[TABLE_ENTRIES];
        logic [OWNER_W-1:0]    key_owner[TABLE_ENTRIES];
        logic [ABIL_W-1:0]     key_ability[TABLE_ENTRIES];
        logic [TIMER_BITS-1:0] remaining[TABLE_ENTRIES];
        t_cooldown_result      pending_results[$];
        int unsigned           errors;

        function new();
            foreach (live[i]) live[i] = 1'b0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void apply_word(t_op op, logic [OWNER_W-1:0] owner,
                                 logic [ABIL_W-1:0] abil, logic [DUR_W-1:0] dur);
            t_cooldown_result r;
            bit               placed;
            int unsigned      n;
            logic [32:0]      tmax;
            r.active  = 1'b0;
            r.dropped = 1'b0;
            placed    = 1'b0;
            n         = 0;
            tmax      = (33'd1 << TIMER_BITS) - 33'd1;
            case (op)
                OP_QUERY: begin
                    foreach (live[i])
                        if (live[i] && key_owner[i] == owner && key_ability[i] == abil)
                            r.active = 1'b1;
                end
                OP_START: begin
                    if (dur != '0) begin
                        foreach (live[i]) begin
                            if (!placed && !live[i]) begin
                                live[i]        = 1'b1;
                                key_owner[i]   = owner;
                                key_ability[i] = abil;
                                remaining[i]   = (33'(dur) > tmax) ? TIMER_BITS'(tmax)
                                                                   : TIMER_BITS'(dur);
                                placed         = 1'b1;
                            end
                        end
                        r.dropped = !placed;
                    end
                end
                OP_CLEAR: begin
                    foreach (live[i])
                        if (live[i] && key_owner[i] == owner)
                            live[i] = 1'b0;
                end
                default: begin
                    foreach (live[i]) begin
                        if (live[i]) begin
                            if (remaining[i] == '0) live[i] = 1'b0;
                            else remaining[i] = remaining[i] - 1'b1;
                        end
                    end
                end
            endcase
            foreach (live[i]) n += live[i];
            r.occupancy = OCC_W'(n);
            pending_results = {pending_results, r};
        endfunction

        function void check_word(logic [15:0] word);
            t_cooldown_result r;
            if (pending_results.size() == 0) begin
                $display("%0t: result word %h with nothing pending", $time, word);
                errors++;
                return;
            end
            r = pending_results.pop_front();
            if (word[0] !== r.active) begin
                $display("%0t: active expected %0d got %0d", $time, r.active, word[0]);
                errors++;
            end
            if (word[1] !== r.dropped) begin
                $display("%0t: dropped expected %0d got %0d", $time, r.dropped, word[1]);
                errors++;
            end
            if (word[8:2] !== r.occupancy) begin
                $display("%0t: occupancy expected %0d got %0d", $time, r.occupancy,
                         word[8:2]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    t_cooldown_scoreboard sb;
    int unsigned          cycle_no    = 0;
    int unsigned          idle_cycles = 0;
    int                   words_sent  = 0;
    bit                   no_gap      = 1'b0;
    logic [OWNER_W-1:0]   owner_pool[POOL_SIZE];

    keyed_cooldown_timer_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 75) return $urandom_range(1, 8);
        if (roll < 95) return $urandom_range(9, 90);
        return $urandom_range(91, 400);
    endfunction

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata);
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // output side: random stalls, one long hold-off, periodic always-ready stretches
    initial begin : ready_gen
        int unsigned span;
        bit          held;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!held && cycle_no >= HOLD_START) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if ((cycle_no / 8000) % 5 == 2) begin
                m_axis_tready <= 1'b1;
                repeat (300) @(posedge i_clk);
            end else begin
                span = pick_gap() + 1;
                m_axis_tready <= 1'b0;
                repeat (span) @(posedge i_clk);
                span = $urandom_range(1, 12);
                m_axis_tready <= 1'b1;
                repeat (span) @(posedge i_clk);
            end
        end
    end

    task automatic send_word(input t_op op, input logic [OWNER_W-1:0] owner,
                             input logic [ABIL_W-1:0] abil, input logic [DUR_W-1:0] dur);
        int unsigned gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, dur, abil, owner, op};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.apply_word(op, owner, abil, dur);
        words_sent++;
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    task automatic send_random_word(input t_mix mix);
        int unsigned        roll;
        int unsigned        roll2;
        t_op                op;
        logic [OWNER_W-1:0] owner;
        logic [ABIL_W-1:0]  abil;
        logic [DUR_W-1:0]   dur;
        roll  = $urandom_range(0, 99);
        roll2 = $urandom_range(0, 99);
        owner = ($urandom_range(0, 99) < 85) ? owner_pool[$urandom_range(0, POOL_SIZE - 1)]
                                             : OWNER_W'($urandom);
        abil  = ($urandom_range(0, 99) < 60) ? ABIL_W'($urandom_range(0, 3))
                                             : ABIL_W'($urandom);
        case (mix)
            MIX_FILL: begin
                op  = roll < 75 ? OP_START : roll < 90 ? OP_QUERY : roll < 93 ? OP_CLEAR
                                                                                : OP_TICK;
                dur = roll2 < 5 ? '0 : DUR_W'($urandom_range(20, 255));
            end
            MIX_DRAIN: begin
                op  = roll < 45 ? OP_TICK : roll < 75 ? OP_QUERY : roll < 90 ? OP_START
                                                                               : OP_CLEAR;
                dur = DUR_W'($urandom_range(0, 6));
            end
            MIX_BALANCED: begin
                op  = t_op'($urandom_range(0, 3));
                dur = roll2 < 10 ? DUR_W'(255) : DUR_W'($urandom_range(0, 20));
            end
            default: begin
                op    = t_op'($urandom_range(0, 3));
                owner = OWNER_W'($urandom);
                abil  = ABIL_W'($urandom);
                dur   = DUR_W'($urandom);
            end
        endcase
        send_word(op, owner, abil, dur);
    endtask

    initial begin : stimulus
        int   phase_len;
        int   roll;
        int   phase_no;
        t_mix mix;
        sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        foreach (owner_pool[i]) owner_pool[i] = OWNER_W'($urandom);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        send_word(OP_QUERY, 16'h0000, 4'd0,  8'd0);
        send_word(OP_TICK,  16'h0000, 4'd0,  8'd0);
        send_word(OP_CLEAR, 16'hFFFF, 4'd15, 8'd0);
        send_word(OP_START, 16'h1234, 4'd5,  8'd0);
        send_word(OP_START, 16'hFFFF, 4'd15, 8'd255);
        send_word(OP_START, 16'h0000, 4'd0,  8'd1);
        send_word(OP_START, 16'hFFFF, 4'd15, 8'd2);
        send_word(OP_QUERY, 16'hFFFF, 4'd15, 8'd0);
        send_word(OP_QUERY, 16'hFFFF, 4'd14, 8'd0);
        send_word(OP_QUERY, 16'h0000, 4'd0,  8'd0);
        send_word(OP_TICK,  16'h0000, 4'd0,  8'd0);
        send_word(OP_TICK,  16'hFFFF, 4'd15, 8'd255);
        send_word(OP_QUERY, 16'h0000, 4'd0,  8'd0);
        send_word(OP_START, 16'h00AA, 4'd3,  8'd1);
        send_word(OP_CLEAR, 16'hFFFF, 4'd0,  8'd0);
        send_word(OP_QUERY, 16'hFFFF, 4'd15, 8'd0);
        send_word(OP_START, 16'h5555, 4'd10, 8'd128);
        send_word(OP_CLEAR, 16'h1234, 4'd5,  8'd0);
        send_word(OP_TICK,  16'h0000, 4'd0,  8'd0);
        send_word(OP_TICK,  16'h0000, 4'd0,  8'd0);
        send_word(OP_QUERY, 16'h00AA, 4'd3,  8'd0);
        send_word(OP_CLEAR, 16'h5555, 4'd10, 8'd0);
        wait_all_results();

        // random phases
        phase_no = 0;
        while (words_sent < TOTAL_WORDS) begin
            roll = $urandom_range(0, 99);
            mix  = roll < 30 ? MIX_FILL : roll < 60 ? MIX_DRAIN : roll < 90 ? MIX_BALANCED
                                                                            : MIX_NOISE;
            phase_len = (mix == MIX_FILL) ? $urandom_range(60, 150) : $urandom_range(40, 120);
            no_gap    = ($urandom_range(0, 99) < 20);
            repeat (phase_len) begin
                if (words_sent < TOTAL_WORDS) send_random_word(mix);
            end
            no_gap = 1'b0;
            // keep offering words while the output side is held off
            if ((phase_no == 0 || $urandom_range(0, 99) < 15) &&
                (cycle_no + 2000 < HOLD_START ||
                 cycle_no > HOLD_START + HOLD_CYCLES + 1000))
                wait_all_results();
            phase_no++;
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
